// ===== rtl/ckc_pkg.sv =====
// shared types, constants and keyword tables for the command keyword classifier
`timescale 1ns / 1ps
`default_nettype none
package ckc_pkg;

    // default number of payload fields before the field number saturates
    localparam int MAX_FIELDS_DEFAULT = 16;

    // entries in the queue between classifier and emitter (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // keyword table
    localparam int NUM_KW     = 11;
    localparam int KW_MAX_LEN = 11;

    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
        {"SEND", "_MSG"}, "GET_MSG", "KEEPALIVE", "CONNECT", "LEAVE", "STATUSREQ",
        "LISTSERVERS", "SERVERS", "STATUSRESP", "GETMSG", "SENDMSG"
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd8, 4'd7, 4'd9, 4'd7, 4'd5, 4'd9, 4'd11, 4'd7, 4'd10, 4'd6, 4'd7
    };

    // result kinds
    localparam logic [1:0] KIND_VERDICT   = 2'd0;
    localparam logic [1:0] KIND_BYTE      = 2'd1;
    localparam logic [1:0] KIND_FIELD_END = 2'd2;

    // verdict codes
    localparam logic signed [4:0] CODE_MALFORMED = -5'sd1;
    localparam logic signed [4:0] CODE_UNKNOWN   = 5'sd0;

    // byte codes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // one classified input item, expands to one or two result items
    typedef struct packed {
        logic [1:0]        kind;
        logic signed [4:0] code;
        logic [7:0]        data;
        logic [3:0]        field;
        logic              dual;   // a field end follows the first result
        logic              eob;
    } ckc_rec_t;

    // character at a position of a keyword, zero past its end
    function automatic logic [7:0] kw_char(input int k, input int pos);
        int base;
        base = 8 * (int'(KW_LEN[k]) - 1 - pos);
        if (pos < int'(KW_LEN[k])) begin
            return KW_TEXT[k][base +: 8];
        end
        return 8'h00;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/command_keyword_classifier_core.sv =====
// top level of the command keyword classifier
`timescale 1ns / 1ps
`default_nettype none
// Takes one byte of a command buffer per item (tlast marks the final byte) and
// classifies the comma-closed header against eleven keywords, then emits each
// payload byte of a known command with its field number and a field-end item
// for every comma or semicolon. A byte is accepted in every cycle the four-entry
// record queue has room; it waits in the queue until it reaches the head and the
// output register can load. Each result item is a separate transfer at the output
// port, so a payload byte that ends the buffer (byte plus field end) gives two
// transfers; bytes that give no result (skipped buffer, open header) never enter the queue.
// The output register is the only register between queue and port.
module command_keyword_classifier_core #(
    parameter int MAX_FIELDS = ckc_pkg::MAX_FIELDS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire logic        s_axis_tlast,   // end_of_buffer
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [4:0] command_code, [12:5] data_byte,
                                             // [16:13] field_index, [23:17] zero
    output logic [2:0]       m_axis_tuser,   // [1:0] kind, [2] buffer_done
    output logic             m_axis_tlast    // run_last
);
    import ckc_pkg::*;

    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    ckc_rec_t          push_rec;
    ckc_rec_t          head_rec;
    logic [1:0]        out_kind;
    logic signed [4:0] out_code;
    logic [7:0]        out_data;
    logic [3:0]        out_field;
    logic              out_done;

    // classifier
    ckc_front #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_eob   (s_axis_tlast),
        .q_full   (q_full),
        .in_ready (s_axis_tready),
        .push     (push),
        .push_rec (push_rec)
    );

    // record queue
    ckc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_rec (head_rec)
    );

    // emitter
    ckc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_rec  (head_rec),
        .pop       (pop),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_kind  (out_kind),
        .out_code  (out_code),
        .out_data  (out_data),
        .out_field (out_field),
        .out_last  (m_axis_tlast),
        .out_done  (out_done)
    );

    // output packing
    assign m_axis_tdata = {7'd0, out_field, out_data, out_code};
    assign m_axis_tuser = {out_done, out_kind};

endmodule
`default_nettype wire

// ===== rtl/ckc_front.sv =====
// classifier: tracks header and payload, turns each byte into a queue record
`timescale 1ns / 1ps
`default_nettype none
module ckc_front #(
    parameter int MAX_FIELDS = ckc_pkg::MAX_FIELDS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_eob,
    input  wire logic            q_full,
    output logic                 in_ready,
    output logic                 push,
    output ckc_pkg::ckc_rec_t    push_rec
);
    import ckc_pkg::*;

    localparam int FNUM_W = $clog2(MAX_FIELDS);
    localparam logic [FNUM_W-1:0] FNUM_TOP = FNUM_W'(MAX_FIELDS - 1);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_SKIP
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [3:0]          header_length_reg, header_length_next;
    logic [NUM_KW-1:0]   hits_reg, hits_next;
    logic [FNUM_W-1:0]   field_number_reg, field_number_next;

    logic                accept;
    logic                is_word;
    logic [7:0]          upper;
    logic signed [4:0]   verdict;
    logic                emit;
    ckc_rec_t            rec;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // header character class and upper-casing
    always_comb
    begin
        is_word = ((in_byte >= 8'h30) && (in_byte <= 8'h39)) ||
                  ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) ||
                  ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
                  (in_byte == 8'h5F) || (in_byte == 8'h20) ||
                  ((in_byte >= 8'h09) && (in_byte <= 8'h0D));
        upper = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ? (in_byte - 8'd32) : in_byte;
    end

    // keyword lookup at the closing comma, first matching keyword wins
    always_comb
    begin
        verdict = CODE_UNKNOWN;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (hits_reg[k] && (KW_LEN[k] == header_length_reg)) begin
                verdict = 5'(k + 1);
            end
        end
        if (header_length_reg == 4'd0) begin
            verdict = CODE_MALFORMED;
        end
    end

    // next state and record for the current byte
    always_comb
    begin
        phase_next         = phase_reg;
        header_length_next = header_length_reg;
        hits_next          = hits_reg;
        field_number_next  = field_number_reg;
        emit               = 1'b0;
        rec.kind           = KIND_VERDICT;
        rec.code           = CODE_UNKNOWN;
        rec.data           = 8'h00;
        rec.field          = 4'(field_number_reg);
        rec.dual           = 1'b0;
        rec.eob            = in_eob;

        unique case (phase_reg)
            PH_HEADER:
            begin
                rec.field = 4'd0;
                if (is_word) begin
                    for (int k = 0; k < NUM_KW; k++) begin
                        if (kw_char(k, int'(header_length_reg)) != upper) begin
                            hits_next[k] = 1'b0;
                        end
                    end
                    if (header_length_reg != 4'd15) begin
                        header_length_next = header_length_reg + 4'd1;
                    end
                    // header never closed
                    emit     = in_eob;
                    rec.code = CODE_MALFORMED;
                end else if (in_byte == CH_COMMA) begin
                    emit              = 1'b1;
                    rec.code          = verdict;
                    phase_next        = (verdict > 5'sd0) ? PH_PAYLOAD : PH_SKIP;
                    field_number_next = '0;
                end else begin
                    emit       = 1'b1;
                    rec.code   = CODE_MALFORMED;
                    phase_next = PH_SKIP;
                end
            end
            PH_PAYLOAD:
            begin
                emit = 1'b1;
                if ((in_byte == CH_COMMA) || (in_byte == CH_SEMI)) begin
                    rec.kind = KIND_FIELD_END;
                    if (field_number_reg != FNUM_TOP) begin
                        field_number_next = field_number_reg + 1'b1;
                    end
                end else begin
                    rec.kind = KIND_BYTE;
                    rec.data = in_byte;
                    // open field holds this byte, so it closes at buffer end
                    rec.dual = in_eob;
                end
            end
            PH_SKIP:
            begin
                emit = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // buffer end returns everything to the reset state
        if (in_eob) begin
            phase_next         = PH_HEADER;
            header_length_next = 4'd0;
            hits_next          = '1;
            field_number_next  = '0;
        end
    end

    assign push     = accept && emit;
    assign push_rec = rec;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg         <= PH_HEADER;
            header_length_reg <= 4'd0;
            hits_reg          <= '1;
            field_number_reg  <= '0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            header_length_reg <= header_length_next;
            hits_reg          <= hits_next;
            field_number_reg  <= field_number_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ckc_queue.sv =====
// short record queue between classifier and emitter
`timescale 1ns / 1ps
`default_nettype none
module ckc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ckc_pkg::ckc_rec_t push_rec,
    input  wire logic              pop,
    output logic                   full,
    output logic                   empty,
    output ckc_pkg::ckc_rec_t      head_rec
);
    import ckc_pkg::*;

    ckc_rec_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_rec = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ckc_back.sv =====
// emitter: expands queue records into result items behind an output register
`timescale 1ns / 1ps
`default_nettype none
module ckc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire ckc_pkg::ckc_rec_t head_rec,
    output logic                   pop,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [1:0]             out_kind,
    output logic signed [4:0]      out_code,
    output logic [7:0]             out_data,
    output logic [3:0]             out_field,
    output logic                   out_last,
    output logic                   out_done
);
    import ckc_pkg::*;

    logic              valid_reg;
    logic              second_reg, second_next;
    logic              load;
    logic [1:0]        kind_reg, kind_next;
    logic signed [4:0] code_reg, code_next;
    logic [7:0]        data_reg, data_next;
    logic [3:0]        field_reg;
    logic              last_reg, last_next;
    logic              done_reg, done_next;

    assign load = !valid_reg || out_ready;

    // pick the first or the trailing field-end result of the head record
    always_comb
    begin
        if (second_reg) begin
            kind_next   = KIND_FIELD_END;
            code_next   = CODE_UNKNOWN;
            data_next   = 8'h00;
            last_next   = 1'b1;
            done_next   = head_rec.eob;
            second_next = 1'b0;
            pop         = load && !q_empty;
        end else begin
            kind_next   = head_rec.kind;
            code_next   = head_rec.code;
            data_next   = head_rec.data;
            last_next   = !head_rec.dual;
            done_next   = !head_rec.dual && head_rec.eob;
            second_next = head_rec.dual;
            pop         = load && !q_empty && !head_rec.dual;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= !q_empty;
            if (!q_empty) begin
                second_reg <= second_next;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load && !q_empty) begin
            kind_reg  <= kind_next;
            code_reg  <= code_next;
            data_reg  <= data_next;
            field_reg <= head_rec.field;
            last_reg  <= last_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_code  = code_reg;
    assign out_data  = data_reg;
    assign out_field = field_reg;
    assign out_last  = last_reg;
    assign out_done  = done_reg;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the command keyword classifier core
`timescale 1ns / 1ps
module testbench;
    import ckc_pkg::*;

    localparam int NUM_BYTES    = 1650;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AT      = 500;
    localparam int PAUSE_AT     = 1000;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int FIELD_TOP    = MAX_FIELDS_DEFAULT - 1;
    localparam int HDR_LEN_TOP  = 15;

    localparam logic signed [4:0] CODE_LEAVE = 5'sd5;

    typedef enum logic [1:0] {IN_HEADER, IN_PAYLOAD, IN_SKIP} parse_phase_t;

    // one result item split into its fields
    typedef struct {
        logic [1:0]        kind;
        logic signed [4:0] code;
        logic [7:0]        data;
        logic [3:0]        field;
        logic              run_last;
        logic              buffer_done;
    } out_item_t;

    // one row of the directed byte table
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         fixed;
        out_item_t  want;
    } byte_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    command_keyword_classifier_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // keywords in code order, code is index plus one
    string command_words [NUM_KW] = '{
        {"SEND", "_MSG"}, "GET_MSG", "KEEPALIVE", "CONNECT", "LEAVE", "STATUSREQ",
        "LISTSERVERS", "SERVERS", "STATUSRESP", "GETMSG", "SENDMSG"
    };

    // parser state mirrored by the predictor
    parse_phase_t   phase = IN_HEADER;
    int unsigned    header_len = 0;
    logic [10:0]    word_hits = '1;
    int unsigned    field_num = 0;

    out_item_t      step_results [$];
    out_item_t      pending_results [$];
    byte_row_t      directed_bytes [$];

    bit             gaps_on = 1'b1;
    bit             hold_request = 1'b0;
    int             stall_left = 0;
    int             fails = 0;
    int             bytes_counted = 0;
    int unsigned    cycle_count = 0;

    function automatic bit is_word_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
            || c == "_" || c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void clear_parser();
        phase = IN_HEADER;
        header_len = 0;
        word_hits = '1;
        field_num = 0;
    endfunction

    function void add_result(logic [1:0] kind, logic signed [4:0] code, logic [7:0] data,
                             logic [3:0] field);
        out_item_t r;
        r.kind = kind;
        r.code = code;
        r.data = data;
        r.field = field;
        r.run_last = 1'b0;
        r.buffer_done = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    // works out the result items caused by one input byte
    function void classify_byte(logic [7:0] c, logic last);
        logic [7:0]        up;
        logic signed [4:0] verdict;
        step_results.delete();
        case (phase)
            IN_HEADER:
            begin
                if (is_word_char(c))
                begin
                    up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
                    for (int k = 0; k < NUM_KW; k++)
                    begin
                        if (header_len >= command_words[k].len()
                            || 8'(command_words[k][header_len]) != up)
                            word_hits[k] = 1'b0;
                    end
                    if (header_len < HDR_LEN_TOP)
                        header_len++;
                    if (last)
                        add_result(KIND_VERDICT, CODE_MALFORMED, 8'h00, 4'd0);
                end
                else if (c == CH_COMMA)
                begin
                    verdict = CODE_MALFORMED;
                    if (header_len != 0)
                    begin
                        verdict = CODE_UNKNOWN;
                        for (int k = 0; k < NUM_KW; k++)
                        begin
                            if (verdict == CODE_UNKNOWN && word_hits[k]
                                && command_words[k].len() == header_len)
                                verdict = 5'(k + 1);
                        end
                    end
                    add_result(KIND_VERDICT, verdict, 8'h00, 4'd0);
                    phase = (verdict > 0) ? IN_PAYLOAD : IN_SKIP;
                    field_num = 0;
                end
                else
                begin
                    add_result(KIND_VERDICT, CODE_MALFORMED, 8'h00, 4'd0);
                    phase = IN_SKIP;
                end
            end
            IN_PAYLOAD:
            begin
                if (c == CH_COMMA || c == CH_SEMI)
                begin
                    add_result(KIND_FIELD_END, CODE_UNKNOWN, 8'h00, 4'(field_num));
                    if (field_num < FIELD_TOP)
                        field_num++;
                end
                else
                begin
                    add_result(KIND_BYTE, CODE_UNKNOWN, c, 4'(field_num));
                    if (last)
                        add_result(KIND_FIELD_END, CODE_UNKNOWN, 8'h00, 4'(field_num));
                end
            end
            default:
            begin
            end
        endcase
        if (step_results.size() > 0)
        begin
            step_results[step_results.size() - 1].run_last = 1'b1;
            step_results[step_results.size() - 1].buffer_done = last;
        end
        if (last)
            clear_parser();
    endfunction

    // offers one byte, waits for acceptance and queues its expected results
    task automatic send_byte(logic [7:0] ch, logic last, bit fixed, out_item_t want);
        bit live;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        live = (phase != IN_SKIP);
        classify_byte(ch, last);
        if (fixed)
        begin
            step_results.delete();
            step_results.insert(0, want);
        end
        foreach (step_results[i])
            pending_results.insert(pending_results.size(), step_results[i]);
        if (live)
            bytes_counted++;
    endtask

    // directed table rows, with or without a typed-in verdict
    task automatic add_row(logic [7:0] ch, logic last);
        byte_row_t r;
        r.ch = ch;
        r.last = last;
        r.fixed = 1'b0;
        r.want = '{default: '0};
        directed_bytes.insert(directed_bytes.size(), r);
    endtask

    task automatic add_verdict_row(logic [7:0] ch, logic last, logic signed [4:0] code);
        byte_row_t r;
        r.ch = ch;
        r.last = last;
        r.fixed = 1'b1;
        r.want = '{KIND_VERDICT, code, 8'h00, 4'd0, 1'b1, last};
        directed_bytes.insert(directed_bytes.size(), r);
    endtask

    function automatic logic [7:0] random_word_char();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(65, 90));
            1: return 8'($urandom_range(97, 122));
            2: return 8'($urandom_range(48, 57));
            3: return 8'h5F;
            4: return 8'h20;
            default: return 8'($urandom_range(9, 13));
        endcase
    endfunction

    // builds and sends one random buffer
    task automatic send_random_buffer();
        logic [7:0] buf_q [$];
        logic [7:0] c;
        out_item_t  none;
        int         pick;
        int         k;
        int         n;
        none = '{default: '0};
        pick = $urandom_range(0, 99);
        if (pick < 62)
        begin
            // known keyword in mixed case, then payload
            k = $urandom_range(0, NUM_KW - 1);
            for (int i = 0; i < command_words[k].len(); i++)
            begin
                c = 8'(command_words[k][i]);
                if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
                    c = c + 8'd32;
                buf_q.insert(buf_q.size(), c);
            end
            buf_q.insert(buf_q.size(), CH_COMMA);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 24);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 7))
                    0: buf_q.insert(buf_q.size(), CH_COMMA);
                    1: buf_q.insert(buf_q.size(), CH_SEMI);
                    default: buf_q.insert(buf_q.size(), 8'($urandom_range(0, 255)));
                endcase
            end
        end
        else if (pick < 74)
        begin
            // well-formed header, mostly unknown, some past saturation
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
                buf_q.insert(buf_q.size(), random_word_char());
            buf_q.insert(buf_q.size(), CH_COMMA);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                buf_q.insert(buf_q.size(), 8'($urandom_range(0, 255)));
        end
        else if (pick < 86)
        begin
            // header broken by a foreign byte
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
                buf_q.insert(buf_q.size(), random_word_char());
            do
                c = 8'($urandom_range(0, 255));
            while (is_word_char(c) || c == CH_COMMA);
            buf_q.insert(buf_q.size(), c);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                buf_q.insert(buf_q.size(), 8'($urandom_range(0, 255)));
        end
        else if (pick < 92)
        begin
            // empty header
            buf_q.insert(buf_q.size(), CH_COMMA);
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                buf_q.insert(buf_q.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            // header never closed
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                buf_q.insert(buf_q.size(), random_word_char());
        end
        foreach (buf_q[i])
            send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, none);
    endtask

    // result checker and receiver-side stalls
    task automatic compare_field(string name, logic signed [15:0] want,
                                 logic signed [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind = m_axis_tuser[1:0];
                got.buffer_done = m_axis_tuser[2];
                got.code = m_axis_tdata[4:0];
                got.data = m_axis_tdata[12:5];
                got.field = m_axis_tdata[16:13];
                got.run_last = m_axis_tlast;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual kind %0d code %0d",
                             $time, got.kind, got.code);
                    fails++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("kind", want.kind, got.kind);
                    compare_field("command_code", want.code, got.code);
                    compare_field("data_byte", want.data, got.data);
                    compare_field("field_index", want.field, got.field);
                    compare_field("run_last", want.run_last, got.run_last);
                    compare_field("buffer_done", want.buffer_done, got.buffer_done);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        clear_parser();

        // empty header, then a silent final byte
        add_verdict_row(CH_COMMA, 1'b0, CODE_MALFORMED);
        add_row("x", 1'b1);
        // broken header, rest skipped
        add_row("a", 1'b0);
        add_verdict_row("!", 1'b0, CODE_MALFORMED);
        add_row("z", 1'b1);
        // header never closed
        add_row("a", 1'b0);
        add_verdict_row("b", 1'b1, CODE_MALFORMED);
        // known keyword, byte extremes, empty field, trailing field
        add_row("l", 1'b0);
        add_row("e", 1'b0);
        add_row("a", 1'b0);
        add_row("v", 1'b0);
        add_row("e", 1'b0);
        add_verdict_row(CH_COMMA, 1'b0, CODE_LEAVE);
        add_row(8'h00, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(CH_SEMI, 1'b0);
        add_row(CH_COMMA, 1'b0);
        add_row("Z", 1'b1);
        // unknown keyword, payload ignored
        add_row("x", 1'b0);
        add_row("y", 1'b0);
        add_row("z", 1'b0);
        add_verdict_row(CH_COMMA, 1'b0, CODE_UNKNOWN);
        add_row("q", 1'b1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i].ch, directed_bytes[i].last, directed_bytes[i].fixed,
                      directed_bytes[i].want);

        // random buffers
        while (bytes_counted < NUM_BYTES)
        begin
            if ($urandom_range(0, 19) == 0)
                gaps_on = !gaps_on;
            if (bytes_counted >= NUM_BYTES - QUIET_TAIL)
                gaps_on = 1'b0;
            if (!hold_done && bytes_counted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_request = 1'b1;
            end
            if (!pause_done && bytes_counted >= PAUSE_AT)
            begin
                // sender waits until the block has delivered everything
                pause_done = 1'b1;
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            send_random_buffer();
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ckc_pkg.sv
rtl/ckc_front.sv
rtl/ckc_queue.sv
rtl/ckc_back.sv
rtl/command_keyword_classifier_core.sv
test/testbench.sv
